// ----- src/clm_pkg.sv -----
// ----------------------------------------------------------------------------
// clm_pkg: shared constants, types and tables of the camera local move unit
// Holds the fixed-point setup, the CORDIC arctangent table and the item type.
// ----------------------------------------------------------------------------
package clm_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN        = 24;
	localparam int ANGLE_W          = 16;
	localparam int AMT_W            = 32;

	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// arctangent of 2^-i in turn units (2^32 = one turn)
	function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
		case (i)
			5'd0:    atan_turns = 34'sh020000000;
			5'd1:    atan_turns = 34'sh012E4051E;
			5'd2:    atan_turns = 34'sh009FB385B;
			5'd3:    atan_turns = 34'sh0051111D4;
			5'd4:    atan_turns = 34'sh0028B0D43;
			5'd5:    atan_turns = 34'sh00145D7E1;
			5'd6:    atan_turns = 34'sh000A2F61E;
			5'd7:    atan_turns = 34'sh000517C55;
			5'd8:    atan_turns = 34'sh00028BE53;
			5'd9:    atan_turns = 34'sh000145F2F;
			5'd10:   atan_turns = 34'sh0000A2F98;
			5'd11:   atan_turns = 34'sh0000517CC;
			5'd12:   atan_turns = 34'sh000028BE6;
			5'd13:   atan_turns = 34'sh0000145F3;
			5'd14:   atan_turns = 34'sh00000A2FA;
			5'd15:   atan_turns = 34'sh00000517D;
			5'd16:   atan_turns = 34'sh0000028BE;
			5'd17:   atan_turns = 34'sh00000145F;
			5'd18:   atan_turns = 34'sh000000A30;
			5'd19:   atan_turns = 34'sh000000518;
			5'd20:   atan_turns = 34'sh00000028C;
			5'd21:   atan_turns = 34'sh000000146;
			5'd22:   atan_turns = 34'sh0000000A3;
			5'd23:   atan_turns = 34'sh000000051;
			default: atan_turns = 34'sh000000000;
		endcase
	endfunction

	// one angle prepared by the front part
	typedef struct packed {
		logic [1:0]         quad;
		logic               zero_res;
		logic signed [33:0] res;
	} angle_prep_t;

	// one queued move
	typedef struct packed {
		angle_prep_t              yaw;
		angle_prep_t              pitch;
		logic signed [AMT_W-1:0]  fwd;
		logic signed [AMT_W-1:0]  rgt;
		logic signed [AMT_W-1:0]  up;
	} move_item_t;

endpackage

// ----- src/clm_front.sv -----
// ----------------------------------------------------------------------------
// clm_front: accept moves, split each angle into quadrant and residual
// Holds a short queue of classified moves for the back part.
// ----------------------------------------------------------------------------
module clm_front #(
	parameter int ANGLE_BITS = clm_pkg::ANGLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [clm_pkg::ANGLE_W-1:0]        yaw_angle,
	input  logic [clm_pkg::ANGLE_W-1:0]        pitch_angle,
	input  logic signed [clm_pkg::AMT_W-1:0]   forward_amount,
	input  logic signed [clm_pkg::AMT_W-1:0]   right_amount,
	input  logic signed [clm_pkg::AMT_W-1:0]   up_amount,
	output logic                               item_valid,
	input  logic                               item_take,
	output clm_pkg::move_item_t                item
);
	import clm_pkg::*;

	move_item_t slot_q [2];
	logic [1:0] cnt_q;
	logic       wptr_q, rptr_q;
	move_item_t new_item;

	function automatic angle_prep_t prep(input logic [ANGLE_W-1:0] a);
		logic [31:0] t, tr;
		angle_prep_t p;
		begin
			t          = {a[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
			tr         = t + 32'h2000_0000;
			p.quad     = tr[31:30];
			p.res      = 34'($signed({2'b00, t})) - 34'($signed({2'b00, tr[31:30], 30'd0}));
			if (tr[31:30] == 2'd0 && t[31])
				p.res = 34'($signed({2'b00, t})) - 34'sh100000000;
			p.zero_res = (p.res == 34'sd0);
			prep       = p;
		end
	endfunction

	// classify the incoming transaction
	always_comb begin
		new_item.yaw   = prep(yaw_angle);
		new_item.pitch = prep(pitch_angle);
		new_item.fwd   = forward_amount;
		new_item.rgt   = right_amount;
		new_item.up    = up_amount;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rptr_q];

	// store classified moves
	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wptr_q] <= new_item;
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (push && !full)
				wptr_q <= ~wptr_q;
			if (item_take && item_valid)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((item_take && item_valid) ? 1 : 0);
		end
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("front queue overfilled");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !item_take |=> full)
		else $error("front queue lost an item");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !item_valid)
		else $error("empty queue shows an item");
`endif

endmodule

// ----- src/clm_back.sv -----
// ----------------------------------------------------------------------------
// clm_back: run the shared CORDIC on both angles, then form and apply the move
// A sequencer steps one CORDIC rotation per cycle, then multiplies per cycle.
// ----------------------------------------------------------------------------
module clm_back #(
	parameter int FRAC_BITS    = clm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = clm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_take,
	input  clm_pkg::move_item_t               item,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_x,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_y,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_z,
	output logic                              clipped
);
	import clm_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int SH    = 30 - FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CORD = 4'd1;
	localparam logic [3:0] ST_FIN  = 4'd2;
	localparam logic [3:0] ST_M1   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_M5   = 4'd7;
	localparam logic [3:0] ST_M6   = 4'd8;
	localparam logic [3:0] ST_SUM  = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0]         state_q;
	logic [4:0]         step_q;
	logic               ang_q;
	move_item_t         it_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [33:0] fx_q, fz_q;
	logic signed [65:0] px_q, pz_q, py_q;
	logic signed [65:0] prod;
	logic signed [33:0] ma, mb;
	logic signed [33:0] cam_x_q, cam_y_q, cam_z_q;
	logic               out_full_q;
	logic [1:0]         sg;

	function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
		rnd = (v + (66'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [33:0] sat(input logic signed [65:0] v, output logic c);
		begin
			c = 1'b0;
			if (v > 66'sd2147483647) begin
				c = 1'b1; sat = 34'sd2147483647;
			end else if (v < -66'sd2147483648) begin
				c = 1'b1; sat = -34'sd2147483648;
			end else
				sat = v[33:0];
		end
	endfunction

	angle_prep_t cur_ang;
	logic signed [33:0] c0, s0, cq, sq;
	assign cur_ang = ang_q ? it_q.pitch : it_q.yaw;

	// finish one angle: round and rotate by quadrant
	always_comb begin
		if (cur_ang.zero_res) begin
			c0 = 34'sd1 <<< FRAC_BITS;
			s0 = 34'sd0;
		end else begin
			c0 = 34'(rnd(66'(x_q), SH));
			s0 = 34'(rnd(66'(y_q), SH));
		end
		case (cur_ang.quad)
			2'd0:    begin cq = c0;  sq = s0;  end
			2'd1:    begin cq = -s0; sq = c0;  end
			2'd2:    begin cq = -c0; sq = -s0; end
			default: begin cq = s0;  sq = -c0; end
		endcase
	end

	// select the operands of the shared multiplier
	assign sg = (cp_q > 0) ? 2'b01 : ((cp_q < 0) ? 2'b11 : 2'b00);
	always_comb begin
		case (state_q)
			ST_M1:   begin ma = cy_q; mb = cp_q; end
			ST_M2:   begin ma = sy_q; mb = cp_q; end
			ST_M3:   begin ma = fx_q; mb = 34'(it_q.fwd); end
			ST_M4:   begin ma = fz_q; mb = 34'(it_q.fwd); end
			ST_M5:   begin ma = sp_q; mb = 34'(it_q.fwd); end
			ST_M6:   begin ma = (sg == 2'b01) ? -sy_q : ((sg == 2'b11) ? sy_q : 34'sd0);
				mb = 34'(it_q.rgt); end
			default: begin ma = (sg == 2'b01) ? cy_q : ((sg == 2'b11) ? -cy_q : 34'sd0);
				mb = 34'(it_q.rgt); end
		endcase
		prod = 66'(ma) * 66'(mb);
	end

	logic signed [65:0] dx, dy, dz;
	logic cx, cyc, cz;
	logic signed [33:0] nx, ny, nz;
	always_comb begin
		dx = rnd(px_q, FRAC_BITS);
		dz = rnd(pz_q, FRAC_BITS);
		dy = rnd(py_q + (66'(it_q.up) <<< FRAC_BITS), FRAC_BITS);
		nx = sat(66'(cam_x_q) + dx, cx);
		ny = sat(66'(cam_y_q) + dy, cyc);
		nz = sat(66'(cam_z_q) + dz, cz);
	end

	logic signed [33:0] ys, xs, at;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = atan_turns(step_q);

	assign item_take = (state_q == ST_IDLE) && item_valid;
	assign empty     = !out_full_q;

	// sequence one move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= 5'd0;
			ang_q      <= 1'b0;
			out_full_q <= 1'b0;
			cam_x_q    <= 34'sd0;
			cam_y_q    <= 34'sd0;
			cam_z_q    <= 34'sd3 <<< FRAC_BITS;
		end else begin
			if (pop && out_full_q)
				out_full_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (item_valid) begin
					it_q    <= item;
					ang_q   <= 1'b0;
					step_q  <= 5'd0;
					x_q     <= CORDIC_GAIN_Q30;
					y_q     <= 34'sd0;
					z_q     <= item.yaw.res;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!ang_q) begin
						cy_q    <= cq; sy_q <= sq;
						ang_q   <= 1'b1;
						step_q  <= 5'd0;
						x_q     <= CORDIC_GAIN_Q30;
						y_q     <= 34'sd0;
						z_q     <= it_q.pitch.res;
						state_q <= ST_CORD;
					end else begin
						cp_q    <= cq; sp_q <= sq;
						state_q <= ST_M1;
					end
				end
				ST_M1: begin fx_q <= 34'(rnd(prod, FRAC_BITS)); state_q <= ST_M2; end
				ST_M2: begin fz_q <= 34'(rnd(prod, FRAC_BITS)); state_q <= ST_M3; end
				ST_M3: begin px_q <= prod; state_q <= ST_M4; end
				ST_M4: begin pz_q <= prod; state_q <= ST_M5; end
				ST_M5: begin py_q <= prod; state_q <= ST_M6; end
				ST_M6: begin px_q <= px_q + prod; state_q <= ST_SUM; end
				ST_SUM: begin pz_q <= pz_q + prod; state_q <= ST_OUT; end
				ST_OUT: if (!out_full_q || pop) begin
					// apply the move and publish the result
					cam_x_q    <= nx;
					cam_y_q    <= ny;
					cam_z_q    <= nz;
					pos_x      <= nx[31:0];
					pos_y      <= ny[31:0];
					pos_z      <= nz[31:0];
					clipped    <= cx | cyc | cz;
					out_full_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> state_q == ST_CORD)
		else $error("take did not start CORDIC");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q && !pop |=> $stable(pos_x) && $stable(pos_z))
		else $error("waiting result overwritten");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORD |-> step_q < 5'(STEPS))
		else $error("CORDIC step out of range");
`endif

endmodule

// ----- src/camera_local_move_unit.sv -----
// Moves are handled one at a time: a new move is taken only when the previous
// one is done, set by the one CORDIC unit shared by both angles and the one
// multiplier for the seven products.
// A two-entry input queue and one result register decouple both sides.
// Reset (arst_n low) empties the queues and sets the position to (0,0,3.0).
// ----------------------------------------------------------------------------
// camera_local_move_unit: first-person camera move in the camera's own frame
// Front classifies angles and queues moves; back computes and applies them.
// ----------------------------------------------------------------------------
module camera_local_move_unit #(
	parameter int FRAC_BITS    = clm_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS   = clm_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = clm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [clm_pkg::ANGLE_W-1:0]       yaw_angle,
	input  logic [clm_pkg::ANGLE_W-1:0]       pitch_angle,
	input  logic signed [clm_pkg::AMT_W-1:0]  forward_amount,
	input  logic signed [clm_pkg::AMT_W-1:0]  right_amount,
	input  logic signed [clm_pkg::AMT_W-1:0]  up_amount,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_x,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_y,
	output logic signed [clm_pkg::AMT_W-1:0]  pos_z,
	output logic                              clipped
);
	import clm_pkg::*;

	logic       item_valid, item_take;
	move_item_t item;

	clm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk, .arst_n, .push, .full, .yaw_angle, .pitch_angle,
		.forward_amount, .right_amount, .up_amount,
		.item_valid, .item_take, .item
	);

	clm_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .item_valid, .item_take, .item,
		.empty, .pop, .pos_x, .pos_y, .pos_z, .clipped
	);

endmodule
